[hdl/vmc_pkg.sv]
package vmc_pkg;

	localparam int DATA_W     = 32;
	localparam int LEN_W      = 31;
	localparam int SQ_W       = 64;
	localparam int BSQ_W      = 2 * LEN_W;
	localparam int ROOT_W     = 32;
	localparam int UNIT_W     = 31;
	localparam int SH_W       = 5;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = UNIT_W;
	localparam int UNIT_SHIFT = 30;

	// Reset values of the maximum length bound and its square
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = '1;
	localparam logic [BSQ_W-1:0] MAX_SQ_RST     = 62'h3FFF_FFFF_0000_0001;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_MAX  = 2'd1,
		KIND_MIN  = 2'd2
	} clamp_kind_t;

	typedef enum logic {
		REG_MIN_LENGTH = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_index_t;

	// Length bounds as seen by the compare stage
	typedef struct packed {
		logic [BSQ_W-1:0] min_sq;
		logic [BSQ_W-1:0] max_sq;
		logic [LEN_W-1:0] min_len;
		logic [LEN_W-1:0] max_len;
	} bounds_t;

	// Per-request data that rides along the whole pipeline
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		clamp_kind_t              kind;
		logic [LEN_W-1:0]         target;
	} item_t;

	// Request after normalization, ahead of the square root
	typedef struct packed {
		item_t             item;
		logic [DATA_W-1:0] ax;
		logic [DATA_W-1:0] ay;
		logic [SH_W-1:0]   shift;
	} norm_t;

endpackage

[hdl/vmc_if.sv]
interface vmc_vec_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;

	modport source(output valid, output vec_x, output vec_y, input ready);
	modport sink(input valid, input vec_x, input vec_y, output ready);
endinterface

interface vmc_res_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic [1:0]         clamp_kind;

	modport source(output valid, output out_x, output out_y, output clamp_kind, input ready);
	modport sink(input valid, input out_x, input out_y, input clamp_kind, output ready);
endinterface

[hdl/vmc_front.sv]
module vmc_front import vmc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] vec_x,
	input  logic signed [DATA_W-1:0] vec_y,
	input  bounds_t                  bounds,
	output logic                     out_valid,
	output norm_t                    out_data,
	output logic [SQ_W-1:0]          out_rad
);

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [DATA_W-1:0] x_s1, x_s2, x_s3;
	logic signed [DATA_W-1:0] y_s1, y_s2, y_s3;
	logic [DATA_W-1:0]        ax_s1, ax_s2, ax_s3, ax_s4;
	logic [DATA_W-1:0]        ay_s1, ay_s2, ay_s3, ay_s4;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sum_s3, rad_s4, rad_s5;
	item_t                    item_s4, item_s5;
	logic [1:0]               sh_s4;
	logic [SH_W-1:0]          sh_s5;
	logic [DATA_W-1:0]        ax_s5, ay_s5;

	logic [DATA_W-1:0] ax_c, ay_c;
	logic [SQ_W-1:0]   sqx_c, sqy_c;
	logic [SQ_W-1:0]   rad_a, rad_b, rad_c, rad_d, rad_e;
	logic              sh_a, sh_b, sh_c, sh_d, sh_e;
	item_t             item_c;

	// Take absolute values; the most negative input maps to 2^31
	assign ax_c = vec_x[DATA_W-1] ? DATA_W'(-vec_x) : DATA_W'(vec_x);
	assign ay_c = vec_y[DATA_W-1] ? DATA_W'(-vec_y) : DATA_W'(vec_y);

	// Square the magnitudes
	assign sqx_c = ax_s1 * ax_s1;
	assign sqy_c = ay_s1 * ay_s1;

	// Decide the clamp and take the first two normalizing steps
	always_comb begin
		item_c.x      = x_s3;
		item_c.y      = y_s3;
		item_c.kind   = KIND_NONE;
		item_c.target = '0;
		if (sum_s3 != '0) begin
			if (sum_s3 > {2'b00, bounds.max_sq}) begin
				item_c.kind   = KIND_MAX;
				item_c.target = bounds.max_len;
			end else if (sum_s3 < {2'b00, bounds.min_sq}) begin
				item_c.kind   = KIND_MIN;
				item_c.target = bounds.min_len;
			end
		end
		sh_a  = (sum_s3[63:32] == '0);
		rad_a = sh_a ? {sum_s3[31:0], 32'd0} : sum_s3;
		sh_b  = (rad_a[63:48] == '0);
		rad_b = sh_b ? {rad_a[47:0], 16'd0} : rad_a;
	end

	// Finish normalizing: shift by 8, 4 and 2 bits
	always_comb begin
		sh_c  = (rad_s4[63:56] == '0);
		rad_c = sh_c ? {rad_s4[55:0], 8'd0} : rad_s4;
		sh_d  = (rad_c[63:60] == '0);
		rad_d = sh_d ? {rad_c[59:0], 4'd0} : rad_c;
		sh_e  = (rad_d[63:62] == '0);
		rad_e = sh_e ? {rad_d[61:0], 2'd0} : rad_d;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= vec_x;
			y_s1    <= vec_y;
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			sqx_s2  <= sqx_c;
			sqy_s2  <= sqy_c;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			sum_s3  <= sqx_s2 + sqy_s2;
			item_s4 <= item_c;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			rad_s4  <= rad_b;
			sh_s4   <= {sh_a, sh_b};
			item_s5 <= item_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			rad_s5  <= rad_e;
			sh_s5   <= {sh_s4, sh_c, sh_d, sh_e};
		end
	end

	assign out_valid      = valid_s5;
	assign out_data.item  = item_s5;
	assign out_data.ax    = ax_s5;
	assign out_data.ay    = ay_s5;
	assign out_data.shift = sh_s5;
	assign out_rad        = rad_s5;

endmodule

[hdl/vmc_sqrt.sv]
module vmc_sqrt import vmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  norm_t             in_data,
	input  logic [SQ_W-1:0]   in_rad,
	output logic              out_valid,
	output norm_t             out_data,
	output logic [ROOT_W-1:0] out_root
);

	logic              vld_s  [0:ROOT_STEPS];
	norm_t             dat_s  [0:ROOT_STEPS];
	logic [ROOT_W-1:0] root_s [0:ROOT_STEPS];
	logic [ROOT_W:0]   rem_s  [0:ROOT_STEPS-1];
	logic [SQ_W-1:0]   rad_s  [0:ROOT_STEPS-1];

	assign vld_s[0]  = in_valid;
	assign dat_s[0]  = in_data;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign rad_s[0]  = in_rad;

	// One root bit per stage, two radicand bits consumed per stage
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		logic [ROOT_W+2:0] rem_sh, trial, diff;
		logic              ge;

		assign rem_sh = {rem_s[k], rad_s[k][SQ_W-1 -: 2]};
		assign trial  = {1'b0, root_s[k], 2'b01};
		assign ge     = (rem_sh >= trial);
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_s[k+1]  <= dat_s[k];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			end
		end

		if (k < ROOT_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
					rad_s[k+1] <= {rad_s[k][SQ_W-3:0], 2'b00};
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_STEPS];
	assign out_data  = dat_s[ROOT_STEPS];
	assign out_root  = root_s[ROOT_STEPS];

endmodule

[hdl/vmc_div.sv]
module vmc_div import vmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  norm_t             in_data,
	input  logic [ROOT_W-1:0] in_root,
	output logic              out_valid,
	output item_t             out_item,
	output logic [UNIT_W-1:0] out_ux,
	output logic [UNIT_W-1:0] out_uy
);

	logic              vld_s  [0:DIV_STEPS];
	item_t             item_s [0:DIV_STEPS];
	logic [ROOT_W-1:0] m_s    [0:DIV_STEPS-1];
	logic [ROOT_W-1:0] rx_s   [0:DIV_STEPS-1];
	logic [ROOT_W-1:0] ry_s   [0:DIV_STEPS-1];
	logic [UNIT_W-1:0] qx_s   [1:DIV_STEPS];
	logic [UNIT_W-1:0] qy_s   [1:DIV_STEPS];

	logic [2*DATA_W-1:0] ax_sh, ay_sh;

	// Align each magnitude with the normalized root
	assign ax_sh = {{DATA_W{1'b0}}, in_data.ax} << in_data.shift;
	assign ay_sh = {{DATA_W{1'b0}}, in_data.ay} << in_data.shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_data.item;
			m_s[0]    <= in_root;
			rx_s[0]   <= ax_sh[ROOT_W-1:0];
			ry_s[0]   <= ay_sh[ROOT_W-1:0];
		end
	end

	// Restoring division, one quotient bit per stage for each component
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [ROOT_W:0]   rx_in, ry_in, mx;
		logic [UNIT_W-1:0] qx_in, qy_in;
		logic              gex, gey;
		logic [ROOT_W:0]   dx, dy;

		if (j == 0) begin : g_first
			assign rx_in = {1'b0, rx_s[j]};
			assign ry_in = {1'b0, ry_s[j]};
			assign qx_in = '0;
			assign qy_in = '0;
		end else begin : g_next
			assign rx_in = {rx_s[j], 1'b0};
			assign ry_in = {ry_s[j], 1'b0};
			assign qx_in = qx_s[j];
			assign qy_in = qy_s[j];
		end

		assign mx  = {1'b0, m_s[j]};
		assign gex = (rx_in >= mx);
		assign gey = (ry_in >= mx);
		assign dx  = rx_in - mx;
		assign dy  = ry_in - mx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[j+1] <= item_s[j];
				qx_s[j+1]   <= {qx_in[UNIT_W-2:0], gex};
				qy_s[j+1]   <= {qy_in[UNIT_W-2:0], gey};
			end
		end

		if (j < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[j+1]  <= m_s[j];
					rx_s[j+1] <= gex ? dx[ROOT_W-1:0] : rx_in[ROOT_W-1:0];
					ry_s[j+1] <= gey ? dy[ROOT_W-1:0] : ry_in[ROOT_W-1:0];
				end
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
	assign out_item  = item_s[DIV_STEPS];
	assign out_ux    = qx_s[DIV_STEPS];
	assign out_uy    = qy_s[DIV_STEPS];

endmodule

[hdl/vmc_back.sv]
module vmc_back import vmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  item_t             in_item,
	input  logic [UNIT_W-1:0] in_ux,
	input  logic [UNIT_W-1:0] in_uy,
	output logic              en,
	vmc_res_if.source         res
);

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		clamp_kind_t              kind;
	} result_t;

	localparam int PROD_W = UNIT_W + LEN_W;
	localparam int MAG_W  = PROD_W + 1 - UNIT_SHIFT;

	logic                valid_s1;
	item_t               item_s1;
	logic [PROD_W-1:0]   px_s1, py_s1;
	logic                out_valid_q, skid_valid_q;
	result_t             out_q, skid_q, res_c;
	logic                accept_out;

	// Apply the sign to a rounded magnitude and saturate to 32 bits
	function automatic logic [DATA_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
		input logic neg);
		logic [MAG_W-1:0] lim;
		if (neg) begin
			lim = (mag > MAG_W'(33'h0_8000_0000)) ? MAG_W'(33'h0_8000_0000) : mag;
			return DATA_W'(MAG_W'(0) - lim);
		end
		lim = (mag > MAG_W'(33'h0_7FFF_FFFF)) ? MAG_W'(33'h0_7FFF_FFFF) : mag;
		return lim[DATA_W-1:0];
	endfunction

	// Round half up and pick the passed or the rescaled vector
	always_comb begin
		logic [PROD_W:0] rx, ry;
		rx = {1'b0, px_s1} + (PROD_W+1)'(1 << (UNIT_SHIFT - 1));
		ry = {1'b0, py_s1} + (PROD_W+1)'(1 << (UNIT_SHIFT - 1));
		res_c.kind = item_s1.kind;
		if (item_s1.kind == KIND_NONE) begin
			res_c.x = item_s1.x;
			res_c.y = item_s1.y;
		end else begin
			res_c.x = apply_sign(rx[PROD_W:UNIT_SHIFT], item_s1.x[DATA_W-1]);
			res_c.y = apply_sign(ry[PROD_W:UNIT_SHIFT], item_s1.y[DATA_W-1]);
		end
	end

	assign en         = !skid_valid_q;
	assign accept_out = out_valid_q && res.ready;

	// Scale the unit vector by the target length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			px_s1   <= in_ux * in_item.target;
			py_s1   <= in_uy * in_item.target;
		end
	end

	// Output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (accept_out) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s1) begin
			if (out_valid_q && !res.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (accept_out) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (accept_out) begin
				out_q <= skid_q;
			end
		end else if (valid_s1) begin
			if (out_valid_q && !res.ready) begin
				skid_q <= res_c;
			end else begin
				out_q <= res_c;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_x      = out_q.x;
	assign res.out_y      = out_q.y;
	assign res.clamp_kind = out_q.kind;

endmodule

[hdl/vector_magnitude_clamp.sv]
// Two-dimensional vector length clamp, signed Q16.16 components.
// vec_in carries one request per vector (vec_x, vec_y); vec_out returns one
// result per request, in order: out_x, out_y and clamp_kind (0 unchanged,
// 1 cut to max_length, 2 raised to min_length). A zero vector passes as is.
// Both channels use valid/ready; a request moves when both are high.
// The bounds are written through wr_en/wr_index/wr_data (index 0 min_length,
// index 1 max_length); the user must write them only while no request is in
// flight, as the block does not enforce it. A request passes the front stages
// of absolute value, squaring, sum, compare and normalizing, 32 square root
// stages, one alignment stage and 31 divider stages, one multiply stage and
// the output register. Throughput: one request per cycle while vec_in.ready
// is high, set by the fully pipelined root and divider, each resolving one
// bit per stage. Reset clears all valid bits and sets the bounds to 0 and
// the largest length. When the receiver stalls, one more result goes into a skid
// register; vec_in.ready drops until it empties, and nothing is lost or repeated.
module vector_magnitude_clamp import vmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	vmc_vec_if.sink          vec_in,
	vmc_res_if.source        vec_out,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [LEN_W-1:0] wr_data
);

	logic [LEN_W-1:0] min_len_q, max_len_q;
	logic [BSQ_W-1:0] min_sq_q, max_sq_q;
	bounds_t          bounds;
	logic             en;

	logic              fr_valid;
	norm_t             fr_data;
	logic [SQ_W-1:0]   fr_rad;
	logic              sq_valid;
	norm_t             sq_data;
	logic [ROOT_W-1:0] sq_root;
	logic              dv_valid;
	item_t             dv_item;
	logic [UNIT_W-1:0] dv_ux, dv_uy;

	// Write the bounds and keep their squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '0;
			max_len_q <= MAX_LENGTH_RST;
			min_sq_q  <= '0;
			max_sq_q  <= MAX_SQ_RST;
		end else begin
			if (wr_en) begin
				unique case (reg_index_t'(wr_index))
					REG_MIN_LENGTH: min_len_q <= wr_data;
					REG_MAX_LENGTH: max_len_q <= wr_data;
					default: ;
				endcase
			end
			min_sq_q <= min_len_q * min_len_q;
			max_sq_q <= max_len_q * max_len_q;
		end
	end

	assign bounds.min_sq  = min_sq_q;
	assign bounds.max_sq  = max_sq_q;
	assign bounds.min_len = min_len_q;
	assign bounds.max_len = max_len_q;

	assign vec_in.ready = en;

	vmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec_in.valid && en),
		.vec_x    (vec_in.vec_x),
		.vec_y    (vec_in.vec_y),
		.bounds   (bounds),
		.out_valid(fr_valid),
		.out_data (fr_data),
		.out_rad  (fr_rad)
	);

	vmc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_data  (fr_data),
		.in_rad   (fr_rad),
		.out_valid(sq_valid),
		.out_data (sq_data),
		.out_root (sq_root)
	);

	vmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_data  (sq_data),
		.in_root  (sq_root),
		.out_valid(dv_valid),
		.out_item (dv_item),
		.out_ux   (dv_ux),
		.out_uy   (dv_uy)
	);

	vmc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(dv_valid),
		.in_item (dv_item),
		.in_ux   (dv_ux),
		.in_uy   (dv_uy),
		.en      (en),
		.res     (vec_out)
	);

endmodule

[hdl/vmc_checker.sv]
module vmc_checker import vmc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic [1:0]         clamp_kind
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(clamp_kind))
		else $error("stalled result changed");

	// Report only defined clamp kinds
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clamp_kind == KIND_NONE || clamp_kind == KIND_MAX
			|| clamp_kind == KIND_MIN)
		else $error("undefined clamp kind");

	// Drop request ready only after the receiver stalled a result
	a_fell: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("ready dropped without a stall");

	// While requests are refused a result must be waiting
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("ready low with no result pending");

	// Recheck through $past that a refused request was valid; this always holds
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && in_valid |=> $past(in_valid))
		else $error("request bookkeeping broken");

endmodule

bind vector_magnitude_clamp vmc_checker u_vmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vec_in.valid),
	.in_ready  (vec_in.ready),
	.out_valid (vec_out.valid),
	.out_ready (vec_out.ready),
	.out_x     (vec_out.out_x),
	.out_y     (vec_out.out_y),
	.clamp_kind(vec_out.clamp_kind)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import vmc_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		clamp_kind_t        kind;
	} clamp_res_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic             wr_index;
	logic [LEN_W-1:0] wr_data;

	vmc_vec_if vin ();
	vmc_res_if vres ();

	vector_magnitude_clamp DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec_in   (vin),
		.vec_out  (vres),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Bounds as the block should hold them
	logic [LEN_W-1:0] bound_min;
	logic [LEN_W-1:0] bound_max;

	clamp_res_t clamped_q[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_req;
	int unsigned hold_cnt;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Integer square root, floor
	function automatic logic [63:0] floor_sqrt(input logic [63:0] t_in);
		logic [63:0] t;
		logic [63:0] res;
		logic [63:0] b;
		t = t_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > t)
			b = b >> 2;
		while (b != 0) begin
			if (t >= res + b) begin
				t = t - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Scale one component magnitude to the target length, apply sign, saturate
	function automatic logic signed [31:0] scale_comp(input logic [63:0] a, input logic neg,
			input int unsigned s, input logic [63:0] m, input logic [63:0] target);
		logic [63:0] u;
		logic [63:0] mag;
		u = ((a << s) << UNIT_SHIFT) / m;
		mag = (u * target + (64'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
		if (neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			return 32'(64'd0 - mag);
		end
		if (mag > 64'h7FFF_FFFF)
			mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic clamp_res_t clamp_vector(input logic signed [31:0] x,
			input logic signed [31:0] y);
		clamp_res_t r;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] sq;
		logic [63:0] target;
		logic [63:0] t;
		logic [63:0] m;
		int unsigned s;
		ax = {32'd0, x[31] ? 32'(-x) : x};
		ay = {32'd0, y[31] ? 32'(-y) : y};
		sq = ax * ax + ay * ay;
		r.kind = KIND_NONE;
		target = 0;
		if (sq != 0) begin
			if (sq > 64'(bound_max) * 64'(bound_max)) begin
				r.kind = KIND_MAX;
				target = bound_max;
			end else if (sq < 64'(bound_min) * 64'(bound_min)) begin
				r.kind = KIND_MIN;
				target = bound_min;
			end
		end
		if (r.kind == KIND_NONE) begin
			r.x = x;
			r.y = y;
		end else begin
			s = 0;
			t = sq;
			while (t < (64'd1 << 62)) begin
				t = t << 2;
				s++;
			end
			m = floor_sqrt(t);
			r.x = scale_comp(ax, x[31], s, m, target);
			r.y = scale_comp(ay, y[31], s, m, target);
		end
		return r;
	endfunction

	// Track bound writes
	always @(posedge clk)
		if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_MIN_LENGTH: bound_min <= wr_data;
				REG_MAX_LENGTH: bound_max <= wr_data;
			endcase
		end

	// Predict each accepted request
	always @(posedge clk)
		if (arst_n && vin.valid && vin.ready)
			clamped_q.push_back(clamp_vector(vin.vec_x, vin.vec_y));

	// Compare each accepted result with the oldest prediction
	always @(posedge clk)
		if (arst_n && vres.valid && vres.ready) begin
			if (clamped_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h kind=%0d",
						vres.out_x, vres.out_y, vres.clamp_kind);
			end else begin
				clamp_res_t e;
				e = clamped_q.pop_front();
				if (vres.out_x !== e.x || vres.out_y !== e.y || vres.clamp_kind !== e.kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%h y=%h kind=%0d, got x=%h y=%h kind=%0d",
							e.x, e.y, e.kind, vres.out_x, vres.out_y, vres.clamp_kind);
				end
			end
		end

	// Drive ready, with long hold-offs on request
	always @(posedge clk)
		if (arst_n) begin
			if (hold_req != 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt != 0) begin
				vres.ready <= 1'b0;
				hold_cnt--;
			end else begin
				vres.ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end

	// Stop the run when nothing moves for too long
	always @(posedge clk)
		if (arst_n) begin
			if ((vin.valid && vin.ready) || (vres.valid && vres.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= 5000) begin
				$display("end of test: mismatches");
				$finish;
			end
		end

	task automatic send_vec(input logic signed [31:0] x, input logic signed [31:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			vin.valid <= 1'b0;
			@(posedge clk);
		end
		vin.valid <= 1'b1;
		vin.vec_x <= x;
		vin.vec_y <= y;
		do
			@(posedge clk);
		while (!vin.ready);
	endtask

	// Stop sending and hold until every prediction is checked against a result
	task automatic drain;
		vin.valid <= 1'b0;
		@(posedge clk);
		while (clamped_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_bounds(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
		wr_en <= 1'b1;
		wr_index <= REG_MIN_LENGTH;
		wr_data <= lo;
		@(posedge clk);
		wr_index <= REG_MAX_LENGTH;
		wr_data <= hi;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_comp;
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(3) != 0)
			v = $signed(v) >>> $urandom_range(31);
		return v;
	endfunction

	function automatic logic [LEN_W-1:0] rand_len;
		logic [LEN_W-1:0] v;
		case ($urandom_range(5))
			0: v = 0;
			1: v = '1;
			default: v = LEN_W'($urandom) >> $urandom_range(30);
		endcase
		return v;
	endfunction

	task automatic test_directed;
		logic signed [31:0] ext[6];
		ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1, 32'sh0001_0000};
		// Reset bounds: only the longest vectors get cut
		send_vec(0, 0);
		send_vec(32'sh8000_0000, 32'sh8000_0000);
		send_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_vec(32'sh8000_0000, 0);
		drain();
		// Minimum above maximum; zero vector must stay zero
		set_bounds(31'h0010_0000, 31'h0002_0000);
		for (int i = 0; i < 6; i++)
			send_vec(ext[i], ext[5 - i]);
		send_vec(0, 0);
		send_vec(32'sh0001_8000, -32'sh0000_4000);
		drain();
		// Both bounds at zero: everything nonzero shrinks to nothing
		set_bounds(0, 0);
		send_vec(1, -1);
		send_vec(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_vec(0, 0);
		drain();
		// Both bounds at the top: nonzero vectors grow, but one longer than the bounds is cut
		set_bounds('1, '1);
		send_vec(1, 0);
		send_vec(0, -1);
		send_vec(-32'sh0000_0003, 32'sh0000_0004);
		send_vec(32'sh8000_0000, 32'sh8000_0000);
		send_vec(0, 0);
		drain();
	endtask

	task automatic test_random(input int n_items);
		for (int p = 0; p < n_items / 50; p++) begin
			set_bounds(rand_len(), rand_len());
			for (int i = 0; i < 50; i++)
				send_vec(rand_comp(), rand_comp());
			drain();
		end
	endtask

	task automatic test_backpressure;
		set_bounds(31'h0000_8000, 31'h0040_0000);
		hold_req = 400;
		for (int i = 0; i < 150; i++)
			send_vec(rand_comp(), rand_comp());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MIN_LENGTH;
		wr_data = '0;
		vin.valid = 1'b0;
		vin.vec_x = '0;
		vin.vec_y = '0;
		vres.ready = 1'b0;
		bound_min = '0;
		bound_max = MAX_LENGTH_RST;
		hold_req = 0;
		hold_cnt = 0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 20;
		recv_idle_pct = 54;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(300);
		test_backpressure();
		send_idle_pct = 54;
		recv_idle_pct = 20;
		test_random(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(200);

		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && clamped_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[vector_magnitude_clamp.f]
hdl/vmc_pkg.sv
hdl/vmc_if.sv
hdl/vmc_front.sv
hdl/vmc_sqrt.sv
hdl/vmc_div.sv
hdl/vmc_back.sv
hdl/vector_magnitude_clamp.sv
hdl/vmc_checker.sv
tb/testbench.sv
